// ===== design/assert_macros.svh =====
// Assertion macros shared by the scroll delta divider RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SDD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define SDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sdd_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types
// for the scroll delta divider. No dependencies.
package sdd_pkg;

  localparam int DELTA_BITS_DEF   = 16;
  localparam int DIVISOR_BITS_DEF = 8;
  localparam int WHEEL_BITS       = 8;
  localparam int DIVISOR_RESET    = 8;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCROLL_DIVISOR = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HSCROLL_OFF    = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture report, form remainder sums
    logic to_abs;  // sums to sign and magnitude
    logic step;    // one restoring division step on both axes
    logic commit;  // write result registers and remainders
  } sdd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scroll;  // captured report is in scroll mode
  } sdd_stat_t;

endpackage

// ===== design/scroll_delta_divider.sv =====
// Scroll delta divider: one result per pointer-motion report. A report with
// scroll_mode low passes through the ABS and DONE states to the result. A
// scroll report also runs the DIV state between them: the two axes share
// one step counter and each runs a bit-serial restoring divider, one
// quotient bit per cycle over the SUM_BITS-wide remainder sum, where
// SUM_BITS = max(DELTA_BITS, DIVISOR_BITS + 1) + 1. One report is in
// work at a time; the next is accepted once the current result has moved
// into the output register, even while that result is still stalled.
// Depends on sdd_pkg, sdd_ctrl, sdd_dp and assert_macros.svh.
`include "assert_macros.svh"

module scroll_delta_divider #(
  parameter int DELTA_BITS   = sdd_pkg::DELTA_BITS_DEF,
  parameter int DIVISOR_BITS = sdd_pkg::DIVISOR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sdd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [DIVISOR_BITS-1:0]               cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DELTA_BITS-1:0]          delta_x,
  input  logic signed [DELTA_BITS-1:0]          delta_y,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_h_in,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_v_in,
  input  logic                                  scroll_mode,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [DELTA_BITS-1:0]          cursor_x,
  output logic signed [DELTA_BITS-1:0]          cursor_y,
  output logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_h,
  output logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_v
);
  import sdd_pkg::*;

  localparam int WIDE_BITS = (DELTA_BITS > DIVISOR_BITS + 1) ? DELTA_BITS : DIVISOR_BITS + 1;
  localparam int SUM_BITS  = WIDE_BITS + 1;

  sdd_cmd_t  cmd;
  sdd_stat_t stat;

  assign cfg_ready = 1'b1;

  sdd_ctrl #(
    .STEPS (SUM_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdd_dp #(
    .DELTA_BITS   (DELTA_BITS),
    .DIVISOR_BITS (DIVISOR_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .delta_x     (delta_x),
    .delta_y     (delta_y),
    .wheel_h_in  (wheel_h_in),
    .wheel_v_in  (wheel_v_in),
    .scroll_mode (scroll_mode),
    .cursor_x    (cursor_x),
    .cursor_y    (cursor_y),
    .wheel_h     (wheel_h),
    .wheel_v     (wheel_v)
  );

  `SDD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted report did not hold off the input")
  `SDD_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, out_valid, "committed result not presented")
  `SDD_ASSERT(a_step_busy, clk, rst, !(cmd.step || cmd.to_abs) || in_stall, "divider active while input open")
  `SDD_ASSERT_NEXT(a_taken_drops, clk, rst, out_valid && !out_stall && !cmd.commit, !out_valid, "result repeated after transaction")

endmodule

// ===== design/sdd_ctrl.sv =====
// Sequencer for the scroll delta divider: handshakes, step counter, commands.
// Depends on sdd_pkg.
module sdd_ctrl #(
  parameter int STEPS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sdd_pkg::sdd_stat_t  stat,
  output sdd_pkg::sdd_cmd_t   cmd
);
  import sdd_pkg::*;

  localparam int CNT_BITS = $clog2(STEPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ABS  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                out_take;

  assign in_stall = (state != ST_IDLE);
  assign out_take = out_valid && !out_stall;

  assign cmd.load   = (state == ST_IDLE) && in_valid;
  assign cmd.to_abs = (state == ST_ABS);
  assign cmd.step   = (state == ST_DIV);
  // result register frees up in the same cycle it is taken
  assign cmd.commit = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ABS;
      end
      ST_ABS: begin
        cnt_next   = '0;
        state_next = stat.scroll ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_BITS'(STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/sdd_dp.sv =====
// Datapath for the scroll delta divider: config registers, remainders and two
// bit-serial restoring dividers stepped in lockstep. Depends on sdd_pkg.
module sdd_dp #(
  parameter int DELTA_BITS   = sdd_pkg::DELTA_BITS_DEF,
  parameter int DIVISOR_BITS = sdd_pkg::DIVISOR_BITS_DEF,
  parameter int SUM_BITS     = 17
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sdd_pkg::sdd_cmd_t                    cmd,
  output sdd_pkg::sdd_stat_t                   stat,
  input  logic                                 cfg_write,
  input  logic [sdd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [DIVISOR_BITS-1:0]              cfg_data,
  input  logic signed [DELTA_BITS-1:0]         delta_x,
  input  logic signed [DELTA_BITS-1:0]         delta_y,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_h_in,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_v_in,
  input  logic                                 scroll_mode,
  output logic signed [DELTA_BITS-1:0]         cursor_x,
  output logic signed [DELTA_BITS-1:0]         cursor_y,
  output logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_h,
  output logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_v
);
  import sdd_pkg::*;

  localparam int REM_BITS = DIVISOR_BITS + 1;

  logic [DIVISOR_BITS-1:0] divisor;
  logic                    hscroll_off;
  logic [DIVISOR_BITS-1:0] d_eff;

  logic [REM_BITS-1:0] h_rem, v_rem;

  logic [DELTA_BITS-1:0] dx_q, dy_q, neg_dy;
  logic [WHEEL_BITS-1:0] wh_q, wv_q;
  logic                  scroll_q;

  // sum, then magnitude, then quotient shifting in from the bottom
  logic [SUM_BITS-1:0] a_h, a_v;
  logic                sign_h, sign_v;
  logic [REM_BITS-1:0] pr_h, pr_v;
  logic [REM_BITS-1:0] rs_h, rs_v;
  logic                ge_h, ge_v;

  assign d_eff  = (divisor == '0) ? DIVISOR_BITS'(1) : divisor;
  assign neg_dy = '0 - delta_y;
  assign stat.scroll = scroll_q;

  assign rs_h = {pr_h[DIVISOR_BITS-1:0], a_h[SUM_BITS-1]};
  assign rs_v = {pr_v[DIVISOR_BITS-1:0], a_v[SUM_BITS-1]};
  assign ge_h = (rs_h >= {1'b0, d_eff});
  assign ge_v = (rs_v >= {1'b0, d_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor     <= DIVISOR_BITS'(DIVISOR_RESET);
      hscroll_off <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_SCROLL_DIVISOR) divisor <= cfg_data;
      else if (cfg_index == REG_HSCROLL_OFF) hscroll_off <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_rem <= '0;
      v_rem <= '0;
    end else if (cmd.commit) begin
      if (!scroll_q) begin
        h_rem <= '0;
        v_rem <= '0;
      end else begin
        h_rem <= hscroll_off ? '0 : (sign_h ? ('0 - pr_h) : pr_h);
        v_rem <= sign_v ? ('0 - pr_v) : pr_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_q     <= delta_x;
      dy_q     <= delta_y;
      wh_q     <= wheel_h_in;
      wv_q     <= wheel_v_in;
      scroll_q <= scroll_mode;
      a_h <= {{(SUM_BITS-REM_BITS){h_rem[REM_BITS-1]}}, h_rem}
           + {{(SUM_BITS-DELTA_BITS){delta_x[DELTA_BITS-1]}}, delta_x};
      a_v <= {{(SUM_BITS-REM_BITS){v_rem[REM_BITS-1]}}, v_rem}
           + {{(SUM_BITS-DELTA_BITS){neg_dy[DELTA_BITS-1]}}, neg_dy};
    end else if (cmd.to_abs) begin
      sign_h <= a_h[SUM_BITS-1];
      sign_v <= a_v[SUM_BITS-1];
      a_h    <= a_h[SUM_BITS-1] ? ('0 - a_h) : a_h;
      a_v    <= a_v[SUM_BITS-1] ? ('0 - a_v) : a_v;
      pr_h   <= '0;
      pr_v   <= '0;
    end else if (cmd.step) begin
      pr_h <= ge_h ? (rs_h - {1'b0, d_eff}) : rs_h;
      pr_v <= ge_v ? (rs_v - {1'b0, d_eff}) : rs_v;
      a_h  <= {a_h[SUM_BITS-2:0], ge_h};
      a_v  <= {a_v[SUM_BITS-2:0], ge_v};
    end
  end

  // quotient sign follows the sum; only the low wheel bits are kept
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!scroll_q) begin
        cursor_x <= dx_q;
        cursor_y <= dy_q;
        wheel_h  <= wh_q;
        wheel_v  <= wv_q;
      end else begin
        cursor_x <= '0;
        cursor_y <= '0;
        if (hscroll_off) wheel_h <= '0;
        else wheel_h <= sign_h ? ('0 - a_h[WHEEL_BITS-1:0]) : a_h[WHEEL_BITS-1:0];
        wheel_v <= sign_v ? ('0 - a_v[WHEEL_BITS-1:0]) : a_v[WHEEL_BITS-1:0];
      end
    end
  end

endmodule

// ===== tb/sv/scroll_report_checker.sv =====
// Result checker for scroll_delta_divider: watches the register, report and result
// channels, predicts every result and compares it field by field.
// Depends on sdd_pkg.
module scroll_report_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [sdd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [sdd_pkg::DIVISOR_BITS_DEF-1:0]  cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [sdd_pkg::DELTA_BITS_DEF-1:0] delta_x,
  input  logic signed [sdd_pkg::DELTA_BITS_DEF-1:0] delta_y,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_h_in,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_v_in,
  input  logic                                  scroll_mode,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [sdd_pkg::DELTA_BITS_DEF-1:0] cursor_x,
  input  logic signed [sdd_pkg::DELTA_BITS_DEF-1:0] cursor_y,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_h,
  input  logic signed [sdd_pkg::WHEEL_BITS-1:0] wheel_v,
  output int                                    mismatches,
  output int                                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdd_pkg::*;

  localparam int DW = DELTA_BITS_DEF;

  typedef struct packed {
    logic signed [DW-1:0]         cursor_x;
    logic signed [DW-1:0]         cursor_y;
    logic signed [WHEEL_BITS-1:0] wheel_h;
    logic signed [WHEEL_BITS-1:0] wheel_v;
  } motion_report_t;

  logic [DIVISOR_BITS_DEF-1:0] divisor;
  logic                        hscroll_off;
  int                          horiz_rem;
  int                          vert_rem;
  int                          fail_count = 0;
  motion_report_t              expected_reports[$];

  assign mismatches = fail_count;

  function automatic motion_report_t predict_report(
    input logic signed [DW-1:0]         dx,
    input logic signed [DW-1:0]         dy,
    input logic signed [WHEEL_BITS-1:0] wh,
    input logic signed [WHEEL_BITS-1:0] wv,
    input logic                         sm
  );
    motion_report_t r;
    int d;
    int q;
    logic signed [DW-1:0] ny;
    if (!sm) begin
      horiz_rem = 0;
      vert_rem = 0;
      r.cursor_x = dx;
      r.cursor_y = dy;
      r.wheel_h = wh;
      r.wheel_v = wv;
      return r;
    end
    d = (divisor == '0) ? 1 : int'(divisor);
    // negation stays in delta width, so the most negative value maps to itself
    ny = -dy;
    r.cursor_x = '0;
    r.cursor_y = '0;
    if (hscroll_off) begin
      horiz_rem = 0;
      r.wheel_h = '0;
    end else begin
      horiz_rem += dx;
      q = horiz_rem / d;
      horiz_rem -= q * d;
      r.wheel_h = q[WHEEL_BITS-1:0];
    end
    vert_rem += ny;
    q = vert_rem / d;
    vert_rem -= q * d;
    r.wheel_v = q[WHEEL_BITS-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [DW-1:0] want,
                             input logic signed [DW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    motion_report_t want;
    if (rst) begin
      divisor = DIVISOR_BITS_DEF'(DIVISOR_RESET);
      hscroll_off = 1'b0;
      horiz_rem = 0;
      vert_rem = 0;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with no report pending, expected none, actual %0d %0d %0d %0d",
                   $time, cursor_x, cursor_y, wheel_h, wheel_v);
        end else begin
          want = expected_reports.pop_front();
          check_field("cursor_x", want.cursor_x, cursor_x);
          check_field("cursor_y", want.cursor_y, cursor_y);
          check_field("wheel_h", want.wheel_h, wheel_h);
          check_field("wheel_v", want.wheel_v, wheel_v);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCROLL_DIVISOR: divisor = cfg_data;
          REG_HSCROLL_OFF:    hscroll_off = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(predict_report(delta_x, delta_y, wheel_h_in, wheel_v_in,
                                                  scroll_mode));
    end
    outstanding <= expected_reports.size();
  end

endmodule

// ===== tb/sv/scroll_delta_divider_tb.sv =====
// Testbench top for scroll_delta_divider: clock, reset, register writes, motion
// reports with random idling on both sides, and the verdict.
// Depends on sdd_pkg, the scroll_delta_divider RTL and scroll_report_checker.
module scroll_delta_divider_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdd_pkg::*;

  localparam int DW = DELTA_BITS_DEF;
  localparam int VW = DIVISOR_BITS_DEF;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASES        = 10;
  localparam int PHASE_REPORTS = 48;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [VW-1:0]               cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [DW-1:0]        delta_x = '0;
  logic signed [DW-1:0]        delta_y = '0;
  logic signed [WHEEL_BITS-1:0] wheel_h_in = '0;
  logic signed [WHEEL_BITS-1:0] wheel_v_in = '0;
  logic                        scroll_mode = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [DW-1:0]        cursor_x;
  logic signed [DW-1:0]        cursor_y;
  logic signed [WHEEL_BITS-1:0] wheel_h;
  logic signed [WHEEL_BITS-1:0] wheel_v;
  int                          mismatches;
  int                          outstanding;

  int   cycle_count = 0;
  int   n_scroll = 0;
  int   n_pass = 0;
  int   n_cfg = 0;
  logic offering = 1'b0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  scroll_delta_divider uut (.*);

  scroll_report_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len(input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, long_max);
  endfunction

  // deltas near the divisor exercise remainder carry, full range hits wrapping
  function automatic logic signed [DW-1:0] rand_delta(input logic [VW-1:0] div);
    int span;
    span = 4 * int'(div) + 3;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(DW-1){1'b0}}};
          1: return {1'b0, {(DW-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4, 5: return DW'($urandom_range(0, 2 * span) - span);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic send_report(input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy,
                             input logic signed [WHEEL_BITS-1:0] wh,
                             input logic signed [WHEEL_BITS-1:0] wv, input logic sm);
    int n;
    in_valid <= 1'b1;
    offering = 1'b1;
    delta_x <= dx;
    delta_y <= dy;
    wheel_h_in <= wh;
    wheel_v_in <= wv;
    scroll_mode <= sm;
    do @(posedge clk); while (in_stall);
    if (sm) n_scroll++;
    else n_pass++;
    n = idle_len(60);
    if (n > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (outstanding != 0);
  endtask

  // cfg_valid stays high across back-to-back writes; the caller lowers it
  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [VW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
  endtask

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = idle_len(40);
        out_stall <= (n > 0);
        if (n > 1) repeat (n - 1) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [VW-1:0] div;
    logic sm;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // pass-through extremes, then accumulation at the reset divisor
    send_report(-32768, 32767, -128, 127, 1'b0);
    send_report(32767, -32768, 127, -128, 1'b0);
    send_report(7, -7, 8'sh55, -8'sh2B, 1'b1);
    send_report(1, -1, 0, 0, 1'b1);
    send_report(-9, 9, 1, -1, 1'b1);
    send_report(-32768, -32768, 0, 0, 1'b1);
    send_report(0, 0, 0, 0, 1'b0);

    // zero divisor acts as one; quotient wraps to 8 bits
    wait_drained();
    cfg_write(REG_SCROLL_DIVISOR, 8'd0);
    cfg_valid <= 1'b0;
    send_report(200, -200, 0, 0, 1'b1);
    send_report(-32768, 32767, 0, 0, 1'b1);

    wait_drained();
    cfg_write(REG_SCROLL_DIVISOR, 8'd255);
    cfg_valid <= 1'b0;
    send_report(32767, -32767, 0, 0, 1'b1);
    send_report(-32768, 32767, 0, 0, 1'b1);
    send_report(254, -254, 0, 0, 1'b1);

    // horizontal scroll off keeps only bit 0; spare indexes are ignored
    wait_drained();
    cfg_write(REG_HSCROLL_OFF, 8'hFF);
    cfg_write(REG_SPARE_2, 8'h03);
    cfg_write(REG_SPARE_3, 8'h01);
    cfg_valid <= 1'b0;
    send_report(500, -500, 9, 9, 1'b1);
    send_report(-1, 1, 0, 0, 1'b1);
    send_report(123, -456, 5, -6, 1'b0);

    wait_drained();
    cfg_write(REG_HSCROLL_OFF, 8'hFE);
    cfg_write(REG_SCROLL_DIVISOR, 8'd3);
    cfg_valid <= 1'b0;
    send_report(32767, -32767, 0, 0, 1'b1);
    send_report(-32768, -32768, 0, 0, 1'b1);
    send_report(2, 2, 0, 0, 1'b1);
    send_report(1, -1, 0, 0, 1'b1);
    send_report(-5, 5, -1, 1, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: div = 8'd0;
        1: div = 8'd255;
        2: div = 8'd1;
        3: div = 8'd2;
        default: div = VW'($urandom_range(0, 255));
      endcase
      cfg_write(REG_SCROLL_DIVISOR, div);
      cfg_write(REG_HSCROLL_OFF, (p == 1) ? 8'h01 : VW'($urandom));
      if ($urandom_range(0, 2) == 0)
        cfg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3, VW'($urandom));
      cfg_valid <= 1'b0;
      quiet = (p == 4 || p == 6);
      // long output hold-off while reports keep coming back to back
      if (p == 6) hold_req = 1'b1;
      for (int i = 0; i < PHASE_REPORTS; i++) begin
        if (!quiet && $urandom_range(0, 39) == 0) wait_drained();
        sm = ($urandom_range(0, 9) != 0);
        send_report(rand_delta(div), rand_delta(div), WHEEL_BITS'($urandom),
                    WHEEL_BITS'($urandom), sm);
      end
    end
    quiet = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered %0d motion reports (%0d scroll, %0d pass-through), %0d register writes,",
             n_scroll + n_pass, n_scroll, n_pass, n_cfg);
    $display("divisors 0 to 255, horizontal scroll on and off, a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
